### rtl/cbt_pkg.sv
// shared types, constants and helpers of the can bit-timing calculator
// no dependencies; used by every module under rtl
package cbt_pkg;

    localparam int unsigned LANES    = 4;
    localparam int unsigned DW       = 32;
    localparam int unsigned VW       = 36;
    localparam int unsigned STAGES   = DW;

    localparam logic [1:0] LANE16 = 2'd0;
    localparam logic [1:0] LANE12 = 2'd1;
    localparam logic [1:0] LANE10 = 2'd2;
    localparam logic [1:0] LANE8  = 2'd3;

    localparam logic [15:0] SEG16 = 16'h3534;
    localparam logic [15:0] SEG12 = 16'h2422;
    localparam logic [15:0] SEG10 = 16'h2312;
    localparam logic [15:0] SEG8  = 16'h1211;

    localparam logic [31:0] RATE_SPECIAL      = 32'd83333;
    localparam logic [31:0] CLOCK_MIN_SPECIAL = 32'd1000000;
    localparam logic [31:0] PRESCALE_MAX      = 32'd127;
    localparam logic [31:0] CLOCK_RESET       = 32'd48000000;

    localparam logic [1:0] ST_OK  = 2'd0;
    localparam logic [1:0] ST_OFF = 2'd1;
    localparam logic [1:0] ST_BAD = 2'd2;
    localparam logic [1:0] ST_OVF = 2'd3;

    typedef struct packed {
        logic [31:0] bit_rate;
        logic        listen_only;
    } cbt_in_t;

    typedef struct packed {
        logic [31:0] timing_word;
        logic        enable;
        logic        listen_mode;
        logic [1:0]  status;
    } cbt_out_t;

    // one lane per quanta count: remainder and quotient of clock / (n * rate)
    typedef struct packed {
        logic [LANES-1:0][VW-1:0] rem;
        logic [LANES-1:0][DW-1:0] quo;
        logic [DW-1:0]            dvd;
        logic [31:0]              rate;
        logic                     listen_only;
        logic                     special;
        logic                     zero;
    } cbt_work_t;

    // n * rate by shift and add
    function automatic logic [VW-1:0] lane_divisor(input logic [31:0] rate,
                                                   input logic [1:0] lane);
        logic [VW-1:0] r;
        logic [VW-1:0] d;
        r = {4'b0, rate};
        case (lane)
            LANE16:  d = r << 4;
            LANE12:  d = (r << 3) + (r << 2);
            LANE10:  d = (r << 3) + (r << 1);
            LANE8:   d = r << 3;
            default: d = r << 3;
        endcase
        return d;
    endfunction

endpackage

### rtl/cbt_div_stage.sv
// one restoring-division step for all four quanta lanes, registered
// depends on cbt_pkg
module cbt_div_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  logic              valid_in,
    input  cbt_pkg::cbt_work_t work_in,
    output logic              valid_reg,
    output cbt_pkg::cbt_work_t work_reg
);

    cbt_pkg::cbt_work_t work_next;
    logic [cbt_pkg::VW:0] shifted [cbt_pkg::LANES];
    logic [cbt_pkg::VW:0] divisor [cbt_pkg::LANES];
    logic [cbt_pkg::LANES-1:0] qbit;

    always_comb
    begin
        work_next = work_in;
        for (int l = 0; l < cbt_pkg::LANES; l++)
        begin
            shifted[l] = {work_in.rem[l], work_in.dvd[cbt_pkg::DW-1]};
            divisor[l] = {1'b0, cbt_pkg::lane_divisor(work_in.rate, 2'(l))};
            qbit[l]    = (shifted[l] >= divisor[l]);
            if (qbit[l])
            begin
                work_next.rem[l] = cbt_pkg::VW'(shifted[l] - divisor[l]);
            end
            else
            begin
                work_next.rem[l] = shifted[l][cbt_pkg::VW-1:0];
            end
            work_next.quo[l] = {work_in.quo[l][cbt_pkg::DW-2:0], qbit[l]};
        end
        work_next.dvd = {work_in.dvd[cbt_pkg::DW-2:0], 1'b0};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            work_reg <= work_next;
        end
    end

endmodule

### rtl/cbt_decode.sv
// picks the quanta count from the division results and forms the result
// depends on cbt_pkg
module cbt_decode (
    input  cbt_pkg::cbt_work_t work,
    output cbt_pkg::cbt_out_t  result
);

    logic [cbt_pkg::LANES-1:0] fit;
    logic [31:0] q;
    logic [15:0] qm1;
    logic [15:0] seg;
    logic        found;

    always_comb
    begin
        for (int l = 0; l < cbt_pkg::LANES; l++)
        begin
            fit[l] = (work.rem[l] == '0);
        end
        found = 1'b1;
        q     = work.quo[cbt_pkg::LANE16];
        seg   = cbt_pkg::SEG16;
        if (fit[cbt_pkg::LANE16] && q < cbt_pkg::PRESCALE_MAX && q > 32'd1)
        begin
            seg = cbt_pkg::SEG16;
        end
        else if (fit[cbt_pkg::LANE12] || work.special)
        begin
            seg = cbt_pkg::SEG12;
            q   = work.quo[cbt_pkg::LANE12];
        end
        else if (fit[cbt_pkg::LANE10])
        begin
            seg = cbt_pkg::SEG10;
            q   = work.quo[cbt_pkg::LANE10];
        end
        else if (fit[cbt_pkg::LANE8])
        begin
            seg = cbt_pkg::SEG8;
            q   = work.quo[cbt_pkg::LANE8];
        end
        else
        begin
            found = 1'b0;
        end
        // only the low half of the prescaler lands in the word
        qm1 = q[15:0] - 16'd1;

        if (work.zero)
        begin
            result = '{timing_word: '0, enable: 1'b0, listen_mode: 1'b0,
                       status: cbt_pkg::ST_OFF};
        end
        else if (!found)
        begin
            result = '{timing_word: '0, enable: 1'b0, listen_mode: 1'b0,
                       status: cbt_pkg::ST_BAD};
        end
        else
        begin
            result.timing_word = {qm1, seg};
            result.enable      = 1'b1;
            result.listen_mode = work.listen_only;
            result.status      = (q > cbt_pkg::PRESCALE_MAX + 32'd1) ?
                                 cbt_pkg::ST_OVF : cbt_pkg::ST_OK;
        end
    end

endmodule

### rtl/can_bit_timing_calculator_top.sv
// top level of the can bit-timing calculator: clock register, pipeline, output
// depends on cbt_pkg, cbt_div_stage, cbt_decode
//
// usage
//   cfg_wr_en / cfg_wr_data write the peripheral clock in hertz (reset 48 MHz);
//   write it only while no request is in flight
//   input channel: in_valid, in_stall, in_data (bit rate and listen-only flag)
//   output channel: out_valid, out_stall, out_data (timing word, enable,
//   listen mode, status); a transfer happens when valid is high and stall low
// pipeline and throughput
//   registers from input transfer to out_valid: one entry register, 32
//   restoring-division steps (one quotient bit per stage, four quanta lanes
//   side by side dividing the clock by 16, 12, 10 and 8 times the rate),
//   and the output register holding the decoded result
//   one transfer per cycle sustained while a held result is not stalled
// reset
//   all stage valid bits and out_valid clear; the clock register returns to
//   48 MHz
// stall
//   while the output holds a result that is stalled, the whole pipeline
//   freezes and in_stall is raised; bubbles do not freeze it
module can_bit_timing_calculator_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic              in_valid,
    output logic              in_stall,
    input  cbt_pkg::cbt_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output cbt_pkg::cbt_out_t out_data
);

    logic [31:0]        clock_hz_reg;
    logic               advance;
    logic               entry_valid_reg;
    cbt_pkg::cbt_work_t entry_work_reg;
    cbt_pkg::cbt_work_t entry_work_next;
    logic               stage_valid [cbt_pkg::STAGES+1];
    cbt_pkg::cbt_work_t stage_work  [cbt_pkg::STAGES+1];
    cbt_pkg::cbt_out_t  decoded;
    logic               out_valid_reg;
    cbt_pkg::cbt_out_t  out_data_reg;

    // clock register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg <= cbt_pkg::CLOCK_RESET;
        end
        else if (cfg_wr_en)
        begin
            clock_hz_reg <= cfg_wr_data;
        end
    end

    // pipeline moves unless a finished result is held by the receiver
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = !advance;

    // entry: seed the four lanes, the dividend is the clock
    always_comb
    begin
        entry_work_next             = '0;
        entry_work_next.dvd         = clock_hz_reg;
        entry_work_next.rate        = in_data.bit_rate;
        entry_work_next.listen_only = in_data.listen_only;
        entry_work_next.zero        = (in_data.bit_rate == '0);
        entry_work_next.special     = (in_data.bit_rate == cbt_pkg::RATE_SPECIAL) &&
                                      (clock_hz_reg >= cbt_pkg::CLOCK_MIN_SPECIAL);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            entry_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            entry_work_reg <= entry_work_next;
        end
    end

    assign stage_valid[0] = entry_valid_reg;
    assign stage_work[0]  = entry_work_reg;

    // one quotient bit per stage, msb first
    for (genvar k = 1; k <= cbt_pkg::STAGES; k++)
    begin : g_div
        cbt_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .advance   (advance),
            .valid_in  (stage_valid[k-1]),
            .work_in   (stage_work[k-1]),
            .valid_reg (stage_valid[k]),
            .work_reg  (stage_work[k])
        );
    end

    cbt_decode u_decode (
        .work   (stage_work[cbt_pkg::STAGES]),
        .result (decoded)
    );

    // output register parts the pipeline from the receiver
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= stage_valid[cbt_pkg::STAGES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= decoded;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // off and bad rate never enable and never write a word
    a_reject_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.status == cbt_pkg::ST_OFF ||
                      out_data.status == cbt_pkg::ST_BAD)
        |-> !out_data.enable && out_data.timing_word == '0)
        else $error("rejected request carries an enabled result");

    // listen mode only when enabled
    a_listen_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.listen_mode |-> out_data.enable)
        else $error("listen mode without enable");

    // overflow still enables the controller
    a_ovf_enable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status == cbt_pkg::ST_OVF |-> out_data.enable)
        else $error("prescaler overflow without enable");

    // a frozen pipeline keeps its held result
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data_reg))
        else $error("held result changed under stall");

endmodule

### dv/can_bit_timing_calculator_top_tb.sv
// testbench for the can bit-timing calculator top level
// depends on cbt_pkg and can_bit_timing_calculator_top; self-checking scoreboard inside
module can_bit_timing_calculator_top_tb;

    // timing-word predictor and queue of outstanding expected results
    class timing_scoreboard;
        logic [31:0]       clock_hz;
        cbt_pkg::cbt_out_t pending[$];
        int                n_fail;
        int                n_checked;

        function void reset_clock();
            clock_hz = cbt_pkg::CLOCK_RESET;
            n_fail = 0;
            n_checked = 0;
        endfunction

        function bit lane_fits(logic [31:0] clk_v, logic [31:0] rate,
                               int unsigned n);
            return ((clk_v % n) == 0) && (((clk_v / n) % rate) == 0);
        endfunction

        // work out the expected result of one accepted request
        function void note_request(cbt_pkg::cbt_in_t req);
            cbt_pkg::cbt_out_t r;
            logic [31:0]       rate;
            logic [31:0]       q;
            logic [15:0]       seg;
            bit                found;
            rate = req.bit_rate;
            r = '0;
            found = 1'b1;
            seg = '0;
            if (rate == 0)
            begin
                r.status = cbt_pkg::ST_OFF;
                pending.push_back(r);
                return;
            end
            q = clock_hz / 16 / rate;
            if (lane_fits(clock_hz, rate, 16) && q < 127 && q > 1)
            begin
                seg = cbt_pkg::SEG16;
            end
            else if (lane_fits(clock_hz, rate, 12) ||
                     (rate == cbt_pkg::RATE_SPECIAL &&
                      clock_hz >= cbt_pkg::CLOCK_MIN_SPECIAL))
            begin
                seg = cbt_pkg::SEG12;
                q = clock_hz / 12 / rate;
            end
            else if (lane_fits(clock_hz, rate, 10))
            begin
                seg = cbt_pkg::SEG10;
                q = clock_hz / 10 / rate;
            end
            else if (lane_fits(clock_hz, rate, 8))
            begin
                seg = cbt_pkg::SEG8;
                q = clock_hz / 8 / rate;
            end
            else
            begin
                found = 1'b0;
            end
            if (!found)
            begin
                r.status = cbt_pkg::ST_BAD;
            end
            else
            begin
                r.timing_word = {16'h0, seg} | ((q - 32'd1) << 16);
                r.enable = 1'b1;
                r.listen_mode = req.listen_only;
                r.status = (q > cbt_pkg::PRESCALE_MAX + 1) ?
                           cbt_pkg::ST_OVF : cbt_pkg::ST_OK;
            end
            pending.push_back(r);
        endfunction

        function void check_result(cbt_pkg::cbt_out_t got);
            cbt_pkg::cbt_out_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transfer %h", got);
                n_fail++;
                return;
            end
            e = pending.pop_front();
            n_checked++;
            if (got.timing_word !== e.timing_word)
            begin
                $error("timing_word expected %h actual %h", e.timing_word,
                       got.timing_word);
                n_fail++;
            end
            if (got.enable !== e.enable)
            begin
                $error("enable expected %b actual %b", e.enable, got.enable);
                n_fail++;
            end
            if (got.listen_mode !== e.listen_mode)
            begin
                $error("listen_mode expected %b actual %b", e.listen_mode,
                       got.listen_mode);
                n_fail++;
            end
            if (got.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, got.status);
                n_fail++;
            end
        endfunction
    endclass

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [31:0]       cfg_wr_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    cbt_pkg::cbt_in_t  in_data = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    cbt_pkg::cbt_out_t out_data;

    timing_scoreboard sb;
    bit          allow_stall = 1'b1;
    int          n_sent = 0;
    int          n_cfg = 0;

    always #4 clk = ~clk;

    can_bit_timing_calculator_top u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_data    (in_data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

    // gap length: mostly none or short, now and then a long one
    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 93) return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    // drive one request and hold it until the block takes it
    task automatic send_request(logic [31:0] rate, logic lo);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data.bit_rate <= rate;
        in_data.listen_only <= lo;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // transfer happened at this edge; note it before the payload moves
        sb.note_request(in_data);
        n_sent++;
        @(negedge clk);
    endtask

    // register write, only once the pipeline has drained
    task automatic write_clock(logic [31:0] value);
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        sb.clock_hz = value;
        n_cfg++;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // zero, special, random, or near a divisor of clock / n, so the good paths get used
    function automatic logic [31:0] pick_rate(logic [31:0] clk_v);
        int unsigned n;
        int unsigned p;
        logic [31:0] base;
        logic [31:0] d;
        p = $urandom_range(99);
        case ($urandom_range(3))
            0: n = 16;
            1: n = 12;
            2: n = 10;
            default: n = 8;
        endcase
        base = clk_v / n;
        if (p < 8) return 32'd0;
        if (p < 14) return cbt_pkg::RATE_SPECIAL;
        if (p < 24 || base == 0) return $urandom();
        if (p < 32) return $urandom_range(2000, 1);
        // divisor of base when a small factor divides it, else about half of base
        d = $urandom_range(200, 1);
        if (base % d == 0) return base / d;
        return (base >= 2) ? base / 2 + (base % 2) : 32'd1;
    endfunction

    // result side: random stall, checked at the rising edge
    initial
    begin
        int g;
        forever
        begin
            @(negedge clk);
            if (allow_stall && $urandom_range(99) < 20)
            begin
                g = gap_len();
                out_stall <= 1'b1;
                repeat (g + 1) @(negedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                out_stall <= 1'b0;
                repeat (($urandom_range(9) == 0) ? 30 : 0) @(negedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
    end

    // hard limit on the whole run
    initial
    begin
        #20000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        logic [31:0] clocks[8];
        logic [31:0] cv;
        sb = new();
        sb.reset_clock();
        clocks = '{32'd48000000, 32'd0, 32'hFFFFFFFF, 32'd1000000, 32'd999999,
                   32'd16000000, 32'd80000000, 32'd7};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: reset clock, special cases and field extremes
        send_request(32'd0, 1'b1);
        send_request(32'd500000, 1'b1);
        send_request(32'd1000000, 1'b0);
        send_request(32'd83333, 1'b1);
        send_request(32'd3, 1'b0);
        send_request(32'hFFFFFFFF, 1'b1);
        send_request(32'd1, 1'b1);
        send_request(32'd10000, 1'b0);
        send_request(32'd200000, 1'b1);
        send_request(32'd600000, 1'b0);
        send_request(32'd4000000, 1'b1);
        send_request(32'd750000, 1'b0);
        write_clock(32'd0);
        send_request(32'd83333, 1'b1);
        send_request(32'd5, 1'b0);
        send_request(32'd0, 1'b0);
        write_clock(32'hFFFFFFFF);
        send_request(32'hFFFFFFFF, 1'b1);
        send_request(32'd1, 1'b0);
        send_request(32'd83333, 1'b1);
        write_clock(32'd999999);
        send_request(32'd83333, 1'b1);

        // random phases across several clock settings
        for (int ph = 0; ph < 12; ph++)
        begin
            cv = (ph < 8) ? clocks[ph] : $urandom();
            write_clock(cv);
            for (int i = 0; i < 120; i++)
            begin
                send_request(pick_rate(cv), $urandom_range(1));
            end
        end

        // drain
        in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (40) @(negedge clk);
        $display("tb: %0d requests, %0d results checked, %0d clock settings written",
                 n_sent, sb.n_checked, n_cfg);
        if (sb.n_fail == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

### files.f
rtl/cbt_pkg.sv
rtl/cbt_div_stage.sv
rtl/cbt_decode.sv
rtl/can_bit_timing_calculator_top.sv
dv/can_bit_timing_calculator_top_tb.sv
